FILE: hw/rtl/svm_pkg.sv
`default_nettype none

package svm_pkg;

    // Memory and pointer geometry.
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int BYTE_AW   = MEM_AW + 3;
    localparam int PC_BITS   = 16;
    localparam int PTR_W     = 16;
    localparam int WORD_W    = 64;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_TOP = 1'd1;
    localparam logic [CFG_DATA_W-1:0] ENTRY_RST     = 16'h0000;
    localparam logic [CFG_DATA_W-1:0] STACK_TOP_RST = 16'h8000;

    // Command codes.
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_EXEC   = 2'd1;
    localparam logic [1:0] CMD_HWRITE = 2'd2;
    localparam logic [1:0] CMD_HREAD  = 2'd3;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_EXIT = 2'd1;
    localparam logic [1:0] FAULT_OP   = 2'd2;
    localparam logic [1:0] FAULT_ADDR = 2'd3;

    // Opcodes.
    localparam logic [5:0] OP_IMM  = 6'd0;
    localparam logic [5:0] OP_LEA  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_JZ   = 6'd3;
    localparam logic [5:0] OP_JNZ  = 6'd4;
    localparam logic [5:0] OP_CALL = 6'd5;
    localparam logic [5:0] OP_NVAR = 6'd6;
    localparam logic [5:0] OP_DARG = 6'd7;
    localparam logic [5:0] OP_RET  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_EXIT = 6'd38;

    // Payload of one input transaction.
    typedef struct packed {
        logic [1:0]         cmd;
        logic [5:0]         opcode;
        logic signed [63:0] operand;
        logic [11:0]        host_address;
        logic signed [63:0] host_data;
    } t_in_item;

    // Payload of one output transaction.
    typedef struct packed {
        logic [15:0]        next_pc;
        logic signed [63:0] acc_value;
        logic signed [63:0] read_data;
        logic               halted;
        logic [1:0]         fault_code;
        logic signed [63:0] exit_value;
    } t_out_item;

    // Instruction classes as the controller sequences them.
    typedef enum logic [3:0] {
        K_SIMPLE, K_PUSH, K_RET, K_LI, K_LC, K_SI, K_SC,
        K_EXIT, K_ALU, K_MULDIV, K_BAD
    } t_class;

    typedef enum logic [2:0] {
        A_HOST, A_SP_DEC, A_SP, A_BP, A_BP8, A_ACC, A_RDATA, A_TMP
    } t_addr_sel;

    typedef enum logic [1:0] {W_HOST, W_PUSH, W_ACC, W_BYTE} t_wdata_sel;

    typedef enum logic [2:0] {
        CM_NONE, CM_START, CM_EXEC, CM_FAULT_OP, CM_FAULT_ADDR
    } t_commit;

    typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_REM} t_md_op;

    // Controller to datapath commands.
    typedef struct packed {
        logic       latch;
        logic       mem_rd;
        logic       mem_wr;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        logic       save_tmp;
        logic       save_rd;
        logic       md_start;
        t_commit    commit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] cmd;
        t_class     op_class;
        logic       halted;
        logic       host_ok;
        logic       bad_pre;
        logic       bad_ptr;
        logic       md_done;
    } t_dp_status;

    // Maps an opcode to its sequencing class.
    function automatic t_class decode_class(logic [5:0] op);
        t_class k;
        priority if (op <= OP_JNZ || op == OP_DARG) k = K_SIMPLE;
        else if (op == OP_CALL || op == OP_NVAR || op == OP_PUSH) k = K_PUSH;
        else if (op == OP_RET) k = K_RET;
        else if (op == OP_LI) k = K_LI;
        else if (op == OP_LC) k = K_LC;
        else if (op == OP_SI) k = K_SI;
        else if (op == OP_SC) k = K_SC;
        else if (op == OP_MUL || op == OP_DIV || op == OP_MOD) k = K_MULDIV;
        else if (op >= OP_OR && op <= OP_SUB) k = K_ALU;
        else if (op == OP_EXIT) k = K_EXIT;
        else k = K_BAD;
        return k;
    endfunction

    // Aligned word address inside the memory.
    function automatic logic word_ok(logic [63:0] a);
        return (a[2:0] == 3'd0) && ((a >> BYTE_AW) == 64'd0);
    endfunction

    // Byte address inside the memory.
    function automatic logic byte_ok(logic [63:0] a);
        return (a >> BYTE_AW) == 64'd0;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/svm_ram.sv
`default_nettype none

// Single-port RAM with registered read data.
module svm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/svm_md.sv
`default_nettype none

// Iterative multiply and signed divide, one bit per cycle.
module svm_md (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire svm_pkg::t_md_op i_op,
    input  wire logic [63:0]     i_a,
    input  wire logic [63:0]     i_b,
    output logic                 o_done,
    output logic [63:0]          o_result
);

    logic            r_busy;
    logic            r_done;
    logic [5:0]      r_cnt;
    svm_pkg::t_md_op r_op;
    logic [63:0]     r_x;
    logic [63:0]     r_y;
    logic [63:0]     r_acc;
    logic [63:0]     r_a;
    logic            r_neg_q;
    logic            r_neg_r;
    logic            r_bzero;

    logic [63:0] a_mag;
    logic [63:0] b_mag;
    logic [64:0] rem_sh;
    logic [64:0] diff;

    // Magnitudes of the signed operands.
    assign a_mag  = i_a[63] ? (64'd0 - i_a) : i_a;
    assign b_mag  = i_b[63] ? (64'd0 - i_b) : i_b;
    assign rem_sh = {r_acc, r_x[63]};
    assign diff   = rem_sh - {1'b0, r_y};

    // Control and iteration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift-add multiply or restoring divide step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op    <= i_op;
            r_a     <= i_a;
            r_acc   <= '0;
            r_neg_q <= i_a[63] ^ i_b[63];
            r_neg_r <= i_a[63];
            r_bzero <= (i_b == 64'd0);
            if (i_op == svm_pkg::MD_MUL) begin
                r_x <= i_a;
                r_y <= i_b;
            end else begin
                r_x <= a_mag;
                r_y <= b_mag;
            end
        end else if (r_busy) begin
            if (r_op == svm_pkg::MD_MUL) begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[62:0], 1'b0};
                r_y <= {1'b0, r_y[63:1]};
            end else if (!diff[64]) begin
                r_acc <= diff[63:0];
                r_x   <= {r_x[62:0], 1'b1};
            end else begin
                r_acc <= rem_sh[63:0];
                r_x   <= {r_x[62:0], 1'b0};
            end
        end
    end

    // Sign correction and the divide-by-zero cases.
    always_comb begin
        unique case (r_op)
            svm_pkg::MD_MUL: o_result = r_acc;
            svm_pkg::MD_DIV: begin
                if (r_bzero) o_result = '1;
                else o_result = r_neg_q ? (64'd0 - r_x) : r_x;
            end
            default: begin
                if (r_bzero) o_result = r_a;
                else o_result = r_neg_r ? (64'd0 - r_acc) : r_acc;
            end
        endcase
    end

    assign o_done = r_done;

`ifndef SYNTHESIS
    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !r_done)
        else $error("multiply/divide done did not clear on start");
    a_busy_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("multiply/divide busy and done together");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/svm_ctrl.sv
`default_nettype none

// Sequencer: steps each transaction through issue, memory reads, the
// multiply/divide wait, and the output handshake.
module svm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    input  wire svm_pkg::t_dp_status i_status,
    output svm_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_RD1, S_RD2, S_MD, S_OUT} t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '{latch: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0,
                    addr_sel: svm_pkg::A_SP, wdata_sel: svm_pkg::W_ACC,
                    save_tmp: 1'b0, save_rd: 1'b0, md_start: 1'b0,
                    commit: svm_pkg::CM_NONE};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_OUT;
                unique case (i_status.cmd)
                    svm_pkg::CMD_START: o_cmd.commit = svm_pkg::CM_START;
                    svm_pkg::CMD_HWRITE: begin
                        o_cmd.mem_wr    = i_status.host_ok;
                        o_cmd.addr_sel  = svm_pkg::A_HOST;
                        o_cmd.wdata_sel = svm_pkg::W_HOST;
                    end
                    svm_pkg::CMD_HREAD: begin
                        o_cmd.addr_sel = svm_pkg::A_HOST;
                        if (i_status.host_ok) begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_RD1;
                        end
                    end
                    default: begin
                        if (!i_status.halted) begin
                            unique case (i_status.op_class)
                                svm_pkg::K_SIMPLE: o_cmd.commit = svm_pkg::CM_EXEC;
                                svm_pkg::K_BAD: o_cmd.commit = svm_pkg::CM_FAULT_OP;
                                svm_pkg::K_PUSH: begin
                                    if (i_status.bad_pre) begin
                                        o_cmd.commit = svm_pkg::CM_FAULT_ADDR;
                                    end else begin
                                        o_cmd.mem_wr    = 1'b1;
                                        o_cmd.addr_sel  = svm_pkg::A_SP_DEC;
                                        o_cmd.wdata_sel = svm_pkg::W_PUSH;
                                        o_cmd.commit    = svm_pkg::CM_EXEC;
                                    end
                                end
                                default: begin
                                    if (i_status.bad_pre) begin
                                        o_cmd.commit = svm_pkg::CM_FAULT_ADDR;
                                    end else begin
                                        o_cmd.mem_rd = 1'b1;
                                        n_state      = S_RD1;
                                        if (i_status.op_class == svm_pkg::K_RET) begin
                                            o_cmd.addr_sel = svm_pkg::A_BP;
                                        end else if (i_status.op_class == svm_pkg::K_LI ||
                                                     i_status.op_class == svm_pkg::K_LC) begin
                                            o_cmd.addr_sel = svm_pkg::A_ACC;
                                        end else begin
                                            o_cmd.addr_sel = svm_pkg::A_SP;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_RD1: begin
                n_state = S_OUT;
                if (i_status.cmd == svm_pkg::CMD_HREAD) begin
                    o_cmd.save_rd = 1'b1;
                end else begin
                    unique case (i_status.op_class)
                        svm_pkg::K_RET: begin
                            o_cmd.save_tmp = 1'b1;
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.addr_sel = svm_pkg::A_BP8;
                            n_state        = S_RD2;
                        end
                        svm_pkg::K_MULDIV: begin
                            o_cmd.md_start = 1'b1;
                            n_state        = S_MD;
                        end
                        svm_pkg::K_SI: begin
                            if (i_status.bad_ptr) begin
                                o_cmd.commit = svm_pkg::CM_FAULT_ADDR;
                            end else begin
                                o_cmd.mem_wr    = 1'b1;
                                o_cmd.addr_sel  = svm_pkg::A_RDATA;
                                o_cmd.wdata_sel = svm_pkg::W_ACC;
                                o_cmd.commit    = svm_pkg::CM_EXEC;
                            end
                        end
                        svm_pkg::K_SC: begin
                            if (i_status.bad_ptr) begin
                                o_cmd.commit = svm_pkg::CM_FAULT_ADDR;
                            end else begin
                                o_cmd.save_tmp = 1'b1;
                                o_cmd.mem_rd   = 1'b1;
                                o_cmd.addr_sel = svm_pkg::A_RDATA;
                                n_state        = S_RD2;
                            end
                        end
                        default: o_cmd.commit = svm_pkg::CM_EXEC;
                    endcase
                end
            end
            S_RD2: begin
                n_state      = S_OUT;
                o_cmd.commit = svm_pkg::CM_EXEC;
                if (i_status.op_class == svm_pkg::K_SC) begin
                    o_cmd.mem_wr    = 1'b1;
                    o_cmd.addr_sel  = svm_pkg::A_TMP;
                    o_cmd.wdata_sel = svm_pkg::W_BYTE;
                end
            end
            S_MD: begin
                if (i_status.md_done) begin
                    o_cmd.commit = svm_pkg::CM_EXEC;
                    n_state      = S_OUT;
                end
            end
            default: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // State and handshake registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= (n_state != S_IDLE);
            r_out_valid <= (n_state == S_OUT);
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_one_side_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall))
        else $error("input open while a result is pending");
    a_accept_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("input not closed after an accepted transaction");
    a_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mem_rd && o_cmd.mem_wr))
        else $error("memory read and write in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/svm_dp.sv
`default_nettype none

// Datapath: architectural registers, data memory, ALU and the
// multiply/divide unit.
module svm_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire svm_pkg::t_in_item                    i_in,
    input  wire svm_pkg::t_dp_cmd                     i_cmd,
    input  wire logic [svm_pkg::CFG_DATA_W-1:0]       i_entry,
    input  wire logic [svm_pkg::CFG_DATA_W-1:0]       i_stack_top,
    output svm_pkg::t_dp_status                       o_status,
    output svm_pkg::t_out_item                        o_out
);

    svm_pkg::t_in_item            r_item;
    logic [63:0]                  r_acc;
    logic [svm_pkg::PTR_W-1:0]    r_sp;
    logic [svm_pkg::PTR_W-1:0]    r_bp;
    logic [svm_pkg::PC_BITS-1:0]  r_pc;
    logic                         r_halt;
    logic [1:0]                   r_fault;
    logic [63:0]                  r_exit;
    logic [63:0]                  r_rd;
    logic [63:0]                  r_tmp;

    logic [63:0]                  n_acc;
    logic [svm_pkg::PTR_W-1:0]    n_sp;
    logic [svm_pkg::PTR_W-1:0]    n_bp;
    logic [svm_pkg::PC_BITS-1:0]  n_pc;
    logic                         n_halt;
    logic [1:0]                   n_fault;
    logic [63:0]                  n_exit;

    svm_pkg::t_class              op_class;
    logic [5:0]                   op;
    logic [63:0]                  rdata;
    logic [svm_pkg::PTR_W-1:0]    sp_dec;
    logic [svm_pkg::PTR_W-1:0]    sp_inc;
    logic [svm_pkg::PTR_W-1:0]    bp_inc;
    logic [svm_pkg::PC_BITS-1:0]  pc_inc;
    logic [svm_pkg::PC_BITS-1:0]  opd_pc;
    logic [svm_pkg::PTR_W-1:0]    opd_ptr;
    logic [63:0]                  opd_scaled;
    logic [5:0]                   sh;
    logic [63:0]                  alu_res;
    logic [63:0]                  lc_word;
    logic [63:0]                  sc_word;
    logic [63:0]                  byte_addr;
    logic [svm_pkg::MEM_AW-1:0]   mem_idx;
    logic [63:0]                  wdata;
    logic                         md_done;
    logic [63:0]                  md_result;
    svm_pkg::t_md_op              md_op;

    assign op       = r_item.opcode;
    assign op_class = svm_pkg::decode_class(op);

    // Pointer and program counter arithmetic.
    assign sp_dec     = r_sp - svm_pkg::PTR_W'(8);
    assign sp_inc     = r_sp + svm_pkg::PTR_W'(8);
    assign bp_inc     = r_bp + svm_pkg::PTR_W'(8);
    assign pc_inc     = r_pc + ((op <= svm_pkg::OP_DARG) ? svm_pkg::PC_BITS'(2)
                                                          : svm_pkg::PC_BITS'(1));
    assign opd_pc     = r_item.operand[svm_pkg::PC_BITS-1:0];
    assign opd_ptr    = {r_item.operand[svm_pkg::PTR_W-4:0], 3'b000};
    assign opd_scaled = {r_item.operand[60:0], 3'b000};
    assign sh         = r_acc[5:0];

    // Two-operand ALU: stack word on the left, accumulator on the right.
    always_comb begin
        unique case (op)
            svm_pkg::OP_OR:  alu_res = rdata | r_acc;
            svm_pkg::OP_XOR: alu_res = rdata ^ r_acc;
            svm_pkg::OP_AND: alu_res = rdata & r_acc;
            svm_pkg::OP_EQ:  alu_res = {63'd0, rdata == r_acc};
            svm_pkg::OP_NE:  alu_res = {63'd0, rdata != r_acc};
            svm_pkg::OP_LT:  alu_res = {63'd0, $signed(rdata) < $signed(r_acc)};
            svm_pkg::OP_GT:  alu_res = {63'd0, $signed(rdata) > $signed(r_acc)};
            svm_pkg::OP_LE:  alu_res = {63'd0, $signed(rdata) <= $signed(r_acc)};
            svm_pkg::OP_GE:  alu_res = {63'd0, $signed(rdata) >= $signed(r_acc)};
            svm_pkg::OP_SHL: alu_res = rdata << sh;
            svm_pkg::OP_SHR: alu_res = $unsigned($signed(rdata) >>> sh);
            svm_pkg::OP_ADD: alu_res = rdata + r_acc;
            svm_pkg::OP_SUB: alu_res = rdata - r_acc;
            default:         alu_res = '0;
        endcase
    end

    // Byte lanes for load char and store char.
    always_comb begin
        lc_word = rdata >> {r_acc[2:0], 3'b000};
        sc_word = rdata;
        sc_word[{r_tmp[2:0], 3'b000} +: 8] = r_acc[7:0];
    end

    // Memory address and write data selection.
    always_comb begin
        unique case (i_cmd.addr_sel)
            svm_pkg::A_SP_DEC: byte_addr = 64'(sp_dec);
            svm_pkg::A_SP:     byte_addr = 64'(r_sp);
            svm_pkg::A_BP:     byte_addr = 64'(r_bp);
            svm_pkg::A_BP8:    byte_addr = 64'(bp_inc);
            svm_pkg::A_ACC:    byte_addr = r_acc;
            svm_pkg::A_RDATA:  byte_addr = rdata;
            svm_pkg::A_TMP:    byte_addr = r_tmp;
            default:           byte_addr = '0;
        endcase
        if (i_cmd.addr_sel == svm_pkg::A_HOST) begin
            mem_idx = svm_pkg::MEM_AW'(r_item.host_address);
        end else begin
            mem_idx = byte_addr[svm_pkg::BYTE_AW-1:3];
        end
        unique case (i_cmd.wdata_sel)
            svm_pkg::W_HOST: wdata = r_item.host_data;
            svm_pkg::W_PUSH: begin
                if (op == svm_pkg::OP_CALL) wdata = 64'(pc_inc);
                else if (op == svm_pkg::OP_NVAR) wdata = 64'(r_bp);
                else wdata = r_acc;
            end
            svm_pkg::W_ACC:  wdata = r_acc;
            default:         wdata = sc_word;
        endcase
    end

    svm_ram #(
        .WIDTH (svm_pkg::WORD_W),
        .DEPTH (svm_pkg::MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_re    (i_cmd.mem_rd),
        .i_addr  (mem_idx),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_comb begin
        unique case (op)
            svm_pkg::OP_MUL: md_op = svm_pkg::MD_MUL;
            svm_pkg::OP_DIV: md_op = svm_pkg::MD_DIV;
            default:         md_op = svm_pkg::MD_REM;
        endcase
    end

    svm_md u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.md_start),
        .i_op     (md_op),
        .i_a      (rdata),
        .i_b      (r_acc),
        .o_done   (md_done),
        .o_result (md_result)
    );

    // Commit of start, executed instructions and faults.
    always_comb begin
        n_acc   = r_acc;
        n_sp    = r_sp;
        n_bp    = r_bp;
        n_pc    = r_pc;
        n_halt  = r_halt;
        n_fault = r_fault;
        n_exit  = r_exit;
        unique case (i_cmd.commit)
            svm_pkg::CM_START: begin
                n_pc    = svm_pkg::PC_BITS'(i_entry);
                n_sp    = i_stack_top;
                n_bp    = i_stack_top;
                n_halt  = 1'b0;
                n_fault = svm_pkg::FAULT_NONE;
                n_exit  = '0;
            end
            svm_pkg::CM_FAULT_OP: begin
                n_halt  = 1'b1;
                n_fault = svm_pkg::FAULT_OP;
            end
            svm_pkg::CM_FAULT_ADDR: begin
                n_halt  = 1'b1;
                n_fault = svm_pkg::FAULT_ADDR;
            end
            svm_pkg::CM_EXEC: begin
                n_pc = pc_inc;
                unique case (op_class)
                    svm_pkg::K_SIMPLE: begin
                        unique case (op)
                            svm_pkg::OP_IMM: n_acc = r_item.operand;
                            svm_pkg::OP_LEA: n_acc = 64'(r_bp) + opd_scaled;
                            svm_pkg::OP_JMP: n_pc = opd_pc;
                            svm_pkg::OP_JZ:  if (r_acc == 64'd0) n_pc = opd_pc;
                            svm_pkg::OP_JNZ: if (r_acc != 64'd0) n_pc = opd_pc;
                            default:         n_sp = r_sp + opd_ptr;
                        endcase
                    end
                    svm_pkg::K_PUSH: begin
                        n_sp = sp_dec;
                        if (op == svm_pkg::OP_CALL) begin
                            n_pc = opd_pc;
                        end else if (op == svm_pkg::OP_NVAR) begin
                            n_bp = sp_dec;
                            n_sp = sp_dec - opd_ptr;
                        end
                    end
                    svm_pkg::K_RET: begin
                        n_bp = r_tmp[svm_pkg::PTR_W-1:0];
                        n_pc = rdata[svm_pkg::PC_BITS-1:0];
                        n_sp = r_bp + svm_pkg::PTR_W'(16);
                    end
                    svm_pkg::K_LI: n_acc = rdata;
                    svm_pkg::K_LC: n_acc = {{56{lc_word[7]}}, lc_word[7:0]};
                    svm_pkg::K_SI, svm_pkg::K_SC: n_sp = sp_inc;
                    svm_pkg::K_EXIT: begin
                        n_halt  = 1'b1;
                        n_fault = svm_pkg::FAULT_EXIT;
                        n_exit  = rdata;
                    end
                    svm_pkg::K_ALU: begin
                        n_sp  = sp_inc;
                        n_acc = alu_res;
                    end
                    svm_pkg::K_MULDIV: begin
                        n_sp  = sp_inc;
                        n_acc = md_result;
                    end
                    default: n_pc = r_pc;
                endcase
            end
            default: n_pc = r_pc;
        endcase
    end

    // Architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_sp    <= '0;
            r_bp    <= '0;
            r_pc    <= '0;
            r_halt  <= 1'b1;
            r_fault <= svm_pkg::FAULT_NONE;
            r_exit  <= '0;
            r_rd    <= '0;
        end else begin
            r_acc   <= n_acc;
            r_sp    <= n_sp;
            r_bp    <= n_bp;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_fault <= n_fault;
            r_exit  <= n_exit;
            if (i_cmd.latch) begin
                r_rd <= '0;
            end else if (i_cmd.save_rd) begin
                r_rd <= rdata;
            end
        end
    end

    // Transaction and scratch registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in;
        end
        if (i_cmd.save_tmp) begin
            r_tmp <= rdata;
        end
    end

    // Address checks ahead of the first access and on a popped store pointer.
    always_comb begin
        o_status.cmd      = r_item.cmd;
        o_status.op_class = op_class;
        o_status.halted   = r_halt;
        o_status.host_ok  = (32'(r_item.host_address) < 32'(svm_pkg::MEM_WORDS));
        o_status.md_done  = md_done;
        unique case (op_class)
            svm_pkg::K_PUSH: o_status.bad_pre = !svm_pkg::word_ok(64'(sp_dec));
            svm_pkg::K_RET:  o_status.bad_pre = !svm_pkg::word_ok(64'(r_bp)) ||
                                                !svm_pkg::word_ok(64'(bp_inc));
            svm_pkg::K_LI:   o_status.bad_pre = !svm_pkg::word_ok(r_acc);
            svm_pkg::K_LC:   o_status.bad_pre = !svm_pkg::byte_ok(r_acc);
            svm_pkg::K_SI, svm_pkg::K_SC, svm_pkg::K_EXIT, svm_pkg::K_ALU,
            svm_pkg::K_MULDIV: o_status.bad_pre = !svm_pkg::word_ok(64'(r_sp));
            default:         o_status.bad_pre = 1'b0;
        endcase
        unique case (op_class)
            svm_pkg::K_SI: o_status.bad_ptr = !svm_pkg::word_ok(rdata);
            svm_pkg::K_SC: o_status.bad_ptr = !svm_pkg::byte_ok(rdata);
            default:       o_status.bad_ptr = 1'b0;
        endcase
    end

    // Result transaction straight from the registers.
    assign o_out.next_pc    = 16'(r_pc);
    assign o_out.acc_value  = r_acc;
    assign o_out.read_data  = r_rd;
    assign o_out.halted     = r_halt;
    assign o_out.fault_code = r_fault;
    assign o_out.exit_value = r_exit;

`ifndef SYNTHESIS
    a_addr_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit == svm_pkg::CM_FAULT_ADDR) |=>
            (r_halt && r_fault == svm_pkg::FAULT_ADDR))
        else $error("address fault did not halt the core");
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit == svm_pkg::CM_START) |=>
            (!r_halt && r_fault == svm_pkg::FAULT_NONE && r_sp == r_bp))
        else $error("start did not set up the core");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/stack_vm_core.sv
`default_nettype none

// Accumulator-plus-stack processor core. Each input transaction carries one
// command (start, execute one instruction with its operand word, host memory
// write, host memory read) and yields exactly one output transaction with the
// program counter, accumulator, halt and fault status, exit value, and the
// read word for a host read. Transactions are processed one at a time over
// the single-port data memory, one access per cycle, with a registered read:
// start, host write, simple instructions and pushes go from issue straight
// to the output; loads, ALU operations, exit, host reads and word stores add
// one memory read; return and char store add two; multiply, divide and
// remainder add one read and the wait on the multiply/divide unit, which
// retires one bit per cycle. Configuration registers (entry address, stack
// top) are written through their own port, which is always ready; the user
// must write them only while the core is idle; the block does not enforce it.
module stack_vm_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire svm_pkg::t_in_item                    i_in,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output svm_pkg::t_out_item                        o_out,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [svm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [svm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [svm_pkg::CFG_DATA_W-1:0] r_entry;
    logic [svm_pkg::CFG_DATA_W-1:0] r_stack_top;
    svm_pkg::t_dp_cmd               dp_cmd;
    svm_pkg::t_dp_status            dp_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= svm_pkg::ENTRY_RST;
            r_stack_top <= svm_pkg::STACK_TOP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                svm_pkg::CFG_ENTRY:     r_entry     <= i_cfg_data;
                svm_pkg::CFG_STACK_TOP: r_stack_top <= i_cfg_data;
                default:                r_entry     <= r_entry;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    svm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    svm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .i_entry     (r_entry),
        .i_stack_top (r_stack_top),
        .o_status    (dp_status),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: tb/sv/svm_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the core, keeps its own
// copy of the machine state, predicts one result per accepted command and
// compares every accepted result with the oldest prediction.
module svm_checker
    import svm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    localparam logic [63:0] BYTE_LIMIT = 64'(MEM_WORDS) * 64'd8;
    localparam logic [63:0] PTR_MASK   = 64'hFFFF;
    localparam logic [63:0] PCM        = (64'd1 << PC_BITS) - 64'd1;

    // Shadow machine state.
    logic [15:0] entry_q, stack_top_q;
    logic [63:0] acc_q, exit_q;
    logic [15:0] sp_q, bp_q, pc_q;
    logic        halt_q;
    logic [1:0]  fault_q;
    logic [63:0] shadow_mem [MEM_WORDS];

    t_out_item expected_results[$];
    int        mismatches;

    assign o_errors  = mismatches;
    assign o_pending = expected_results.size();

    function automatic logic aligned_in_mem(logic [63:0] a);
        return (a[2:0] == 3'd0) && (a < BYTE_LIMIT);
    endfunction

    // Signed divide or remainder with the core's divide-by-zero conventions.
    function automatic logic [63:0] signed_divide(logic [63:0] a, logic [63:0] b,
                                                  logic want_rem);
        logic        na, nb;
        logic [63:0] ma, mb, q;
        na = a[63];
        nb = b[63];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        if (b == 64'd0) return want_rem ? a : '1;
        if (want_rem) begin
            q = ma % mb;
            return na ? -q : q;
        end
        q = ma / mb;
        return (na != nb) ? -q : q;
    endfunction

    // Binary operation with the popped word as left operand.
    function automatic logic [63:0] alu_result(logic [5:0] op, logic [63:0] a,
                                               logic [63:0] b);
        logic [5:0] sh;
        sh = b[5:0];
        case (op)
            OP_OR:   return a | b;
            OP_XOR:  return a ^ b;
            OP_AND:  return a & b;
            OP_EQ:   return {63'd0, a == b};
            OP_NE:   return {63'd0, a != b};
            OP_LT:   return {63'd0, $signed(a) < $signed(b)};
            OP_GT:   return {63'd0, $signed(a) > $signed(b)};
            OP_LE:   return {63'd0, $signed(a) <= $signed(b)};
            OP_GE:   return {63'd0, $signed(a) >= $signed(b)};
            OP_SHL:  return a << sh;
            OP_SHR:  return $signed(a) >>> sh;
            OP_ADD:  return a + b;
            OP_SUB:  return a - b;
            OP_MUL:  return a * b;
            OP_DIV:  return signed_divide(a, b, 1'b0);
            default: return signed_divide(a, b, 1'b1);
        endcase
    endfunction

    // One instruction on the shadow state.
    task automatic run_instruction(input logic [5:0] op, input logic [63:0] opd);
        logic [63:0] ax, spv, bpv, pcv, a, t, t8, w, wa, wv, wm;
        logic [1:0]  flt;
        logic        wr;
        ax  = acc_q;
        spv = {48'd0, sp_q};
        bpv = {48'd0, bp_q};
        pcv = {48'd0, pc_q};
        flt = FAULT_NONE;
        wr  = 1'b0;
        wa  = '0;
        wv  = '0;
        wm  = '0;
        pcv = (op <= OP_DARG) ? ((pcv + 64'd2) & PCM) : ((pcv + 64'd1) & PCM);
        case (op)
            OP_IMM:  ax = opd;
            OP_LEA:  ax = bpv + (opd << 3);
            OP_JMP:  pcv = opd & PCM;
            OP_JZ:   if (ax == 64'd0) pcv = opd & PCM;
            OP_JNZ:  if (ax != 64'd0) pcv = opd & PCM;
            OP_CALL, OP_NVAR, OP_PUSH: begin
                t = (spv - 64'd8) & PTR_MASK;
                if (!aligned_in_mem(t)) begin
                    flt = FAULT_ADDR;
                end else begin
                    wr = 1'b1;
                    wa = t;
                    wm = '1;
                    wv = (op == OP_CALL) ? pcv : ((op == OP_NVAR) ? bpv : ax);
                    spv = t;
                    if (op == OP_CALL) pcv = opd & PCM;
                    if (op == OP_NVAR) begin
                        bpv = t;
                        spv = (t - (opd << 3)) & PTR_MASK;
                    end
                end
            end
            OP_DARG: spv = (spv + (opd << 3)) & PTR_MASK;
            OP_RET: begin
                t  = bpv;
                t8 = (t + 64'd8) & PTR_MASK;
                if (!aligned_in_mem(t) || !aligned_in_mem(t8)) begin
                    flt = FAULT_ADDR;
                end else begin
                    bpv = shadow_mem[t[14:3]] & PTR_MASK;
                    pcv = shadow_mem[t8[14:3]] & PCM;
                    spv = (t + 64'd16) & PTR_MASK;
                end
            end
            OP_LI: begin
                if (!aligned_in_mem(ax)) flt = FAULT_ADDR;
                else ax = shadow_mem[ax[14:3]];
            end
            OP_LC: begin
                if (ax >= BYTE_LIMIT) begin
                    flt = FAULT_ADDR;
                end else begin
                    w  = shadow_mem[ax[14:3]] >> ({3'd0, ax[2:0]} * 6'd8);
                    ax = {{56{w[7]}}, w[7:0]};
                end
            end
            OP_SI, OP_SC: begin
                if (!aligned_in_mem(spv)) begin
                    flt = FAULT_ADDR;
                end else begin
                    a = shadow_mem[spv[14:3]];
                    if ((op == OP_SI) ? !aligned_in_mem(a) : (a >= BYTE_LIMIT)) begin
                        flt = FAULT_ADDR;
                    end else begin
                        spv = (spv + 64'd8) & PTR_MASK;
                        wr  = 1'b1;
                        wa  = a & ~64'd7;
                        if (op == OP_SI) begin
                            wm = '1;
                            wv = ax;
                        end else begin
                            wm = 64'hFF << ({3'd0, a[2:0]} * 6'd8);
                            wv = (ax & 64'hFF) << ({3'd0, a[2:0]} * 6'd8);
                        end
                    end
                end
            end
            OP_EXIT: begin
                if (!aligned_in_mem(spv)) begin
                    flt = FAULT_ADDR;
                end else begin
                    exit_q = shadow_mem[spv[14:3]];
                    flt    = FAULT_EXIT;
                end
            end
            default: begin
                if (op >= OP_OR && op <= OP_MOD) begin
                    if (!aligned_in_mem(spv)) begin
                        flt = FAULT_ADDR;
                    end else begin
                        a   = shadow_mem[spv[14:3]];
                        spv = (spv + 64'd8) & PTR_MASK;
                        ax  = alu_result(op, a, ax);
                    end
                end else begin
                    flt = FAULT_OP;
                end
            end
        endcase

        // A fault other than exit leaves registers and memory untouched.
        if (flt != FAULT_NONE) begin
            halt_q  = 1'b1;
            fault_q = flt;
        end else if (wr) begin
            shadow_mem[wa[14:3]] = (shadow_mem[wa[14:3]] & ~wm) | (wv & wm);
        end
        if (flt == FAULT_NONE || flt == FAULT_EXIT) begin
            acc_q = ax;
            sp_q  = spv[15:0];
            bp_q  = bpv[15:0];
            pc_q  = pcv[15:0];
        end
    endtask

    // Applies one command and returns the status it leaves behind.
    task automatic predict_command(input t_in_item it, output t_out_item res);
        logic [63:0] rd;
        rd = '0;
        case (it.cmd)
            CMD_START: begin
                pc_q    = entry_q;
                sp_q    = stack_top_q;
                bp_q    = stack_top_q;
                halt_q  = 1'b0;
                fault_q = FAULT_NONE;
                exit_q  = '0;
            end
            CMD_EXEC:   if (!halt_q) run_instruction(it.opcode, it.operand);
            CMD_HWRITE: shadow_mem[it.host_address] = it.host_data;
            default:    rd = shadow_mem[it.host_address];
        endcase
        res.next_pc    = pc_q;
        res.acc_value  = acc_q;
        res.read_data  = rd;
        res.halted     = halt_q;
        res.fault_code = fault_q;
        res.exit_value = exit_q;
    endtask

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    // Monitor: transactions are sampled on the values before each rising edge.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            entry_q     <= ENTRY_RST;
            stack_top_q <= STACK_TOP_RST;
            acc_q       <= '0;
            sp_q        <= '0;
            bp_q        <= '0;
            pc_q        <= '0;
            halt_q      <= 1'b1;
            fault_q     <= FAULT_NONE;
            exit_q      <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ENTRY) entry_q = i_cfg_data;
                else stack_top_q = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_command(i_in, exp_r);
                expected_results.push_back(exp_r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no command outstanding: %h", i_out);
                end else begin
                    exp_r = expected_results.pop_front();
                    report_field("next_pc", 64'(exp_r.next_pc), 64'(i_out.next_pc));
                    report_field("acc_value", exp_r.acc_value, i_out.acc_value);
                    report_field("read_data", exp_r.read_data, i_out.read_data);
                    report_field("halted", 64'(exp_r.halted), 64'(i_out.halted));
                    report_field("fault_code", 64'(exp_r.fault_code),
                                 64'(i_out.fault_code));
                    report_field("exit_value", exp_r.exit_value, i_out.exit_value);
                end
            end
        end
    end

    initial mismatches = 0;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the stack machine core: fills the low and high
// memory windows from the host, runs a directed program, then several
// configuration phases of random well-formed instruction sequences mixed
// with noise.
module tb;
    import svm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int FILL_LOW    = 16;
    localparam int FILL_HIGH   = MEM_WORDS - 128;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors, pending;
    int                    cycles = 0;
    int                    stall_hold = 0;
    logic                  idle_on = 1'b1;

    always #6 i_clk = ~i_clk;

    stack_vm_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    svm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Run watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver stalls; one long hold-off early on lets the core back up.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (cycles == 2000) begin
            out_stall  <= 1'b1;
            stall_hold <= 600;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (!idle_on) begin
            out_stall <= 1'b0;
        end else if (r < 60) begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
        end else if (r < 95) begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 3);
        end else begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(10, 50);
        end
    end

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'h8000_0000_0000_0000;
            2: return '1;
            3: return 64'd0;
            4: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one command and waits until the core takes it.
    task automatic send_command(input logic [1:0] cmd, input logic [5:0] op,
                                input logic [63:0] opd, input logic [11:0] haddr,
                                input logic [63:0] hdata);
        int r, gap;
        r   = $urandom_range(0, 99);
        gap = !idle_on ? 0 : (r < 70 ? $urandom_range(0, 2) :
              (r < 96 ? $urandom_range(3, 8) : $urandom_range(20, 60)));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_item  <= '{cmd: cmd, opcode: op, operand: opd, host_address: haddr,
                      host_data: hdata};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic exec_op(input logic [5:0] op, input logic [63:0] opd);
        send_command(CMD_EXEC, op, opd, 12'($urandom), rand_word());
    endtask

    task automatic start_core();
        send_command(CMD_START, 6'($urandom), rand_word(), 12'($urandom), rand_word());
    endtask

    // Word index inside one of the two windows that are filled at the start.
    function automatic logic [11:0] rand_index();
        if ($urandom_range(0, 1) == 0) return 12'($urandom_range(0, FILL_LOW - 1));
        return 12'($urandom_range(FILL_HIGH, MEM_WORDS - 1));
    endfunction

    function automatic logic [63:0] rand_addr();
        return 64'(rand_index()) << 3;
    endfunction

    // Waits until every result is in and the core has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One random burst: mostly well-formed instruction groups, some noise.
    task automatic random_burst();
        int r;
        logic [63:0] a;
        logic [5:0]  bad_op;
        r = $urandom_range(0, 99);
        a = rand_addr();
        if (r < 12) begin
            exec_op(OP_IMM, rand_word());
        end else if (r < 20) begin
            exec_op(OP_PUSH, rand_word());
        end else if (r < 40) begin
            exec_op(OP_IMM, rand_word());
            exec_op(OP_PUSH, rand_word());
            exec_op(OP_IMM, rand_word());
            exec_op(6'($urandom_range(OP_OR, OP_MOD)), rand_word());
        end else if (r < 48) begin
            exec_op(OP_IMM, a | 64'($urandom_range(0, 7) * ($urandom_range(0, 9) == 0)));
            exec_op(OP_LI, rand_word());
        end else if (r < 54) begin
            exec_op(OP_IMM, a | 64'($urandom_range(0, 7)));
            exec_op(OP_LC, rand_word());
        end else if (r < 64) begin
            exec_op(OP_IMM, ($urandom_range(0, 1)) ? a : a | 64'($urandom_range(0, 7)));
            exec_op(OP_PUSH, rand_word());
            exec_op(OP_IMM, rand_word());
            exec_op(($urandom_range(0, 1)) ? OP_SI : OP_SC, rand_word());
        end else if (r < 72) begin
            exec_op(6'($urandom_range(OP_JMP, OP_JNZ)), rand_word());
        end else if (r < 80) begin
            exec_op(OP_CALL, rand_word());
            exec_op(OP_NVAR, 64'($urandom_range(0, 4)));
            exec_op(OP_LEA, 64'($urandom_range(0, 5)) - 64'd2);
            exec_op(OP_DARG, 64'($urandom_range(0, 3)));
            exec_op(OP_RET, rand_word());
        end else if (r < 84) begin
            exec_op(OP_PUSH, rand_word());
            exec_op(OP_EXIT, rand_word());
        end else if (r < 88) begin
            // Native calls and undefined opcodes, skipping exit.
            bad_op = 6'($urandom_range(30, 62));
            if (bad_op >= OP_EXIT) bad_op = bad_op + 6'd1;
            exec_op(bad_op, rand_word());
        end else if (r < 92) begin
            start_core();
        end else if (r < 96) begin
            send_command(CMD_HREAD, 6'($urandom), rand_word(), rand_index(), rand_word());
        end else begin
            send_command(CMD_HWRITE, 6'($urandom), rand_word(), 12'($urandom), rand_word());
        end
    endtask

    initial begin
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every word that a program or the host can read is written first;
        // stack words are always pushed before they are popped.
        idle_on = 1'b0;
        for (int i = 0; i < FILL_LOW; i++)
            send_command(CMD_HWRITE, 6'($urandom), rand_word(), 12'(i), rand_word());
        for (int i = FILL_HIGH; i < MEM_WORDS; i++)
            send_command(CMD_HWRITE, 6'($urandom), rand_word(), 12'(i), rand_word());
        idle_on = 1'b1;

        // Directed program with the default configuration.
        exec_op(OP_IMM, 64'd5);
        start_core();
        exec_op(OP_IMM, 64'h7FFF_FFFF_FFFF_FFFF);
        exec_op(OP_PUSH, 64'd0);
        exec_op(OP_IMM, 64'h8000_0000_0000_0000);
        exec_op(OP_ADD, 64'd0);
        exec_op(OP_IMM, 64'h8000_0000_0000_0000);
        exec_op(OP_PUSH, 64'd0);
        exec_op(OP_IMM, '1);
        exec_op(OP_DIV, 64'd0);
        exec_op(OP_PUSH, 64'd0);
        exec_op(OP_IMM, 64'd0);
        exec_op(OP_MOD, 64'd0);
        exec_op(OP_PUSH, 64'd0);
        exec_op(OP_IMM, 64'd67);
        exec_op(OP_SHR, 64'd0);
        exec_op(OP_IMM, 64'd16);
        exec_op(OP_PUSH, 64'd0);
        exec_op(OP_IMM, 64'hFFFF_FFFF_FFFF_FF80);
        exec_op(OP_SC, 64'd0);
        exec_op(OP_IMM, 64'd16);
        exec_op(OP_LC, 64'd0);
        exec_op(OP_CALL, 64'hFFFF_FFFF_FFFF_0040);
        exec_op(OP_NVAR, 64'd2);
        exec_op(OP_DARG, 64'd1);
        exec_op(OP_RET, 64'd0);
        exec_op(OP_IMM, 64'd3);
        exec_op(OP_LI, 64'd0);
        start_core();
        exec_op(6'd30, 64'd0);
        start_core();
        exec_op(6'd63, 64'd0);
        start_core();
        exec_op(OP_PUSH, 64'd0);
        exec_op(OP_EXIT, 64'd0);
        exec_op(OP_IMM, 64'd1);
        send_command(CMD_HREAD, 6'd0, 64'd0, 12'hFFF, 64'd0);

        // Random phases, each with its own configuration.
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            case (p)
                0: begin write_cfg(CFG_ENTRY, 16'hFFFF); write_cfg(CFG_STACK_TOP, 16'h8000); end
                1: begin write_cfg(CFG_ENTRY, 16'h0000); write_cfg(CFG_STACK_TOP, 16'h0000); end
                2: begin write_cfg(CFG_ENTRY, 16'($urandom));
                         write_cfg(CFG_STACK_TOP, 16'h0008); end
                3: begin write_cfg(CFG_ENTRY, 16'($urandom));
                         write_cfg(CFG_STACK_TOP, 16'($urandom_range(1, 4096) * 8)); end
                4: begin write_cfg(CFG_ENTRY, 16'($urandom));
                         write_cfg(CFG_STACK_TOP, 16'($urandom_range(0, 32768))); end
                default: begin write_cfg(CFG_ENTRY, 16'($urandom));
                         write_cfg(CFG_STACK_TOP, 16'h4000); end
            endcase
            start_core();
            n = 0;
            while (n < 140) begin
                if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
                random_burst();
                n += 3;
            end
            idle_on = 1'b1;
        end

        // Drain and verdict.
        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
